FILE: design/wah_resonant_filter_core_defines.svh
// assertion macros used by the checker file
`ifndef WAH_RESONANT_FILTER_CORE_DEFINES_SVH
`define WAH_RESONANT_FILTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while reset is low
`define WRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while reset is low
`define WRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wrf_pkg.sv
// package: constants, beat types and helpers for the wah resonant filter
package wrf_pkg;

    localparam int CHANNELS     = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int CHAN_BITS    = 3;
    localparam int ADDR_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FRAC         = 44;
    localparam int WIDE         = 48;
    localparam int INC_BITS     = 45;
    localparam int CFG_IDX_BITS = 2;
    localparam int SLICE        = WIDE / 2;
    localparam int PROD_BITS    = WIDE + SLICE + 1;
    localparam int ACC_BITS     = 2 * WIDE;
    localparam int SUM_BITS     = WIDE + 2;
    localparam int OUT_SHIFT    = FRAC - (SAMPLE_BITS - 1);

    // 0.999 with 44 fraction bits
    localparam logic signed [WIDE-1:0] K_COEF = 48'sd17574593858372;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN_INC = 2'd0,
        CFG_FB1_INC  = 2'd1,
        CFG_FB2_INC  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [CHAN_BITS-1:0]          chan;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [CHAN_BITS-1:0]          out_chan;
    } t_out_beat;

    typedef struct packed {
        logic signed [WIDE-1:0] y1;
        logic signed [WIDE-1:0] y2;
        logic signed [WIDE-1:0] g;
        logic signed [WIDE-1:0] f1;
        logic signed [WIDE-1:0] f2;
    } t_chan_state;

    localparam int STATE_BITS = $bits(t_chan_state);

    function automatic logic signed [WIDE-1:0] sat_wide(input logic signed [ACC_BITS-1:0] v);
        logic signed [WIDE-1:0] r;
        if ((&v[ACC_BITS-1:WIDE-1]) || !(|v[ACC_BITS-1:WIDE-1])) begin
            r = v[WIDE-1:0];
        end else if (v[ACC_BITS-1]) begin
            r = {1'b1, {(WIDE-1){1'b0}}};
        end else begin
            r = {1'b0, {(WIDE-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: design/wrf_ram.sv
// generic single-port-write ram with registered read
module wrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/wah_resonant_filter_core.sv
// top level: per-channel two-pole resonant wah filter
//
// input channel i_in (valid/ready) carries one sample and a channel number per beat;
// output channel o_out (valid/ready) returns one filtered sample and the same channel.
// three increment registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write them only while the block is idle, which the block does not
// enforce; index 3 is ignored. per-channel state (two past outputs, three smoothed
// coefficients) sits in one ram word per channel, read once when a beat is taken and
// written back at the end. each item runs one read, six products of 48 by 48 bits,
// each done on the single shared 48 by 25 bit multiplier (two partial products,
// rounding, sum), then a saturate step and a write-back step. the result becomes
// valid as the block returns to idle, where it takes the next beat; the block takes
// no new beat before it is through with the last one.
// the result waits in an output register; a stalled receiver holds it, the next
// item still runs and only its final cycle waits for the register to free.
// reset clears the increments, the output valid and all channel valid bits, so
// every channel starts from zero state.
module wah_resonant_filter_core import wrf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_beat                i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_beat               o_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [INC_BITS-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_SUM,
        ST_SAT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_GAIN_SMOOTH,
        OP_FB1_SMOOTH,
        OP_FB2_SMOOTH,
        OP_INPUT,
        OP_FB1_TERM,
        OP_FB2_TERM
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic signed [INC_BITS-1:0]    r_inc_g, r_inc_f1, r_inc_f2;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [CHAN_BITS-1:0]          r_chan;
    logic                          r_oob;
    logic [CHANNELS-1:0]           r_valid;
    logic signed [WIDE-1:0]        r_g, r_f1, r_f2, r_y1, r_y2;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [WIDE-1:0]        r_mq;
    logic signed [SUM_BITS-1:0]    r_y0acc;
    logic signed [WIDE-1:0]        r_y0;
    logic                          r_out_valid;
    t_out_beat                     r_out;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic [ADDR_BITS-1:0]          w_addr;
    logic [STATE_BITS-1:0]         w_rd_raw;
    t_chan_state                   w_rd_state;
    t_chan_state                   w_wr_state;
    logic                          w_we;

    logic signed [WIDE-1:0]        w_a, w_b;
    logic signed [SLICE:0]         w_slice;
    logic signed [PROD_BITS-1:0]   w_a_ext, w_s_ext, w_prod;
    logic signed [ACC_BITS-1:0]    w_prod_ext, w_half, w_round_sum, w_shifted;
    logic signed [WIDE-1:0]        w_mq;
    logic signed [INC_BITS-1:0]    w_inc;
    logic signed [ACC_BITS-1:0]    w_smooth_sum, w_y0_ext;
    logic signed [WIDE-1:0]        w_smooth;
    logic signed [SUM_BITS-1:0]    w_mq_ext;
    logic signed [SUM_BITS-1:0]    w_diff, w_dsh;
    logic signed [SAMPLE_BITS-1:0] w_sample;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_addr      = ADDR_BITS'(r_chan);

    assign w_rd_state = t_chan_state'(w_rd_raw);
    assign w_wr_state = '{y1: r_y0, y2: r_y1, g: r_g, f1: r_f1, f2: r_f2};
    assign w_we       = (r_state == ST_DONE) && w_out_free && !r_oob;

    wrf_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_addr),
        .i_wr_data (w_wr_state),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (ADDR_BITS'(i_in.chan)),
        .o_rd_data (w_rd_raw)
    );

    // operand selection for the shared multiplier
    always_comb begin
        case (r_op)
            OP_GAIN_SMOOTH: begin
                w_a   = K_COEF;
                w_b   = r_g;
                w_inc = r_inc_g;
            end
            OP_FB1_SMOOTH: begin
                w_a   = K_COEF;
                w_b   = r_f1;
                w_inc = r_inc_f1;
            end
            OP_FB2_SMOOTH: begin
                w_a   = K_COEF;
                w_b   = r_f2;
                w_inc = r_inc_f2;
            end
            OP_INPUT: begin
                w_a   = r_g;
                w_b   = {{(WIDE-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
                w_inc = r_inc_g;
            end
            OP_FB1_TERM: begin
                w_a   = r_f1;
                w_b   = r_y1;
                w_inc = r_inc_f1;
            end
            OP_FB2_TERM: begin
                w_a   = r_f2;
                w_b   = r_y2;
                w_inc = r_inc_f2;
            end
            default: begin
                w_a   = '0;
                w_b   = '0;
                w_inc = '0;
            end
        endcase
    end

    // low slice unsigned, high slice signed
    assign w_slice = (r_state == ST_MUL_LO) ? {1'b0, w_b[SLICE-1:0]}
                                            : {w_b[WIDE-1], w_b[WIDE-1:SLICE]};
    assign w_a_ext = {{(PROD_BITS-WIDE){w_a[WIDE-1]}}, w_a};
    assign w_s_ext = {{(PROD_BITS-SLICE-1){w_slice[SLICE]}}, w_slice};
    assign w_prod  = w_a_ext * w_s_ext;

    assign w_prod_ext  = {{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
    assign w_half      = (r_op == OP_INPUT) ? (ACC_BITS'(1) <<< (SAMPLE_BITS-2))
                                            : (ACC_BITS'(1) <<< (FRAC-1));
    assign w_round_sum = r_acc + (w_prod_ext <<< SLICE) + w_half;
    assign w_shifted   = (r_op == OP_INPUT) ? (w_round_sum >>> (SAMPLE_BITS-1))
                                            : (w_round_sum >>> FRAC);
    assign w_mq        = sat_wide(w_shifted);

    assign w_smooth_sum = {{(ACC_BITS-INC_BITS){w_inc[INC_BITS-1]}}, w_inc}
                        + {{(ACC_BITS-WIDE){r_mq[WIDE-1]}}, r_mq};
    assign w_smooth     = sat_wide(w_smooth_sum);
    assign w_mq_ext     = {{(SUM_BITS-WIDE){r_mq[WIDE-1]}}, r_mq};
    assign w_y0_ext     = {{(ACC_BITS-SUM_BITS){r_y0acc[SUM_BITS-1]}}, r_y0acc};

    // y0 - y1, rounded to sample precision and saturated
    assign w_diff = {{(SUM_BITS-WIDE){r_y0[WIDE-1]}}, r_y0}
                  - {{(SUM_BITS-WIDE){r_y1[WIDE-1]}}, r_y1}
                  + (SUM_BITS'(1) <<< (OUT_SHIFT-1));
    assign w_dsh  = w_diff >>> OUT_SHIFT;

    always_comb begin
        if ((&w_dsh[SUM_BITS-1:SAMPLE_BITS-1]) || !(|w_dsh[SUM_BITS-1:SAMPLE_BITS-1])) begin
            w_sample = w_dsh[SAMPLE_BITS-1:0];
        end else if (w_dsh[SUM_BITS-1]) begin
            w_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_GAIN_SMOOTH;
            r_inc_g     <= '0;
            r_inc_f1    <= '0;
            r_inc_f2    <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN_INC: r_inc_g  <= i_cfg_data;
                    CFG_FB1_INC:  r_inc_f1 <= i_cfg_data;
                    CFG_FB2_INC:  r_inc_f2 <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_x    <= i_in.sample_in;
                        r_chan <= i_in.chan;
                        if ({1'b0, i_in.chan} >= (CHAN_BITS+1)'(CHANNELS)) begin
                            r_oob   <= 1'b1;
                            r_state <= ST_DONE;
                        end else begin
                            r_oob   <= 1'b0;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    // a channel never written reads as zero
                    if (r_valid[w_addr]) begin
                        r_y1 <= w_rd_state.y1;
                        r_y2 <= w_rd_state.y2;
                        r_g  <= w_rd_state.g;
                        r_f1 <= w_rd_state.f1;
                        r_f2 <= w_rd_state.f2;
                    end else begin
                        r_y1 <= '0;
                        r_y2 <= '0;
                        r_g  <= '0;
                        r_f1 <= '0;
                        r_f2 <= '0;
                    end
                    r_op    <= OP_GAIN_SMOOTH;
                    r_state <= ST_MUL_LO;
                end
                ST_MUL_LO: begin
                    r_prod  <= w_prod;
                    r_state <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    r_acc   <= w_prod_ext;
                    r_prod  <= w_prod;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_mq    <= w_mq;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    case (r_op)
                        OP_GAIN_SMOOTH: r_g     <= w_smooth;
                        OP_FB1_SMOOTH:  r_f1    <= w_smooth;
                        OP_FB2_SMOOTH:  r_f2    <= w_smooth;
                        OP_INPUT:       r_y0acc <= w_mq_ext;
                        OP_FB1_TERM:    r_y0acc <= r_y0acc - w_mq_ext;
                        OP_FB2_TERM:    r_y0acc <= r_y0acc - w_mq_ext;
                        default: ;
                    endcase
                    if (r_op == OP_FB2_TERM) begin
                        r_state <= ST_SAT;
                    end else begin
                        r_op    <= t_op'(r_op + 3'd1);
                        r_state <= ST_MUL_LO;
                    end
                end
                ST_SAT: begin
                    r_y0    <= sat_wide(w_y0_ext);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out.out_chan <= r_chan;
                        if (r_oob) begin
                            r_out.sample_out <= '0;
                        end else begin
                            r_out.sample_out <= w_sample;
                            r_valid[w_addr]  <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/wrf_checker.sv
// port-level checker for the wah resonant filter core, with its bind
`include "wah_resonant_filter_core_defines.svh"

module wrf_checker import wrf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pend;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // beats taken in and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    `WRF_ASSERT_NOW(a_no_orphan_out, o_out_valid, r_pend != 2'd0, "result beat without input beat")
    `WRF_ASSERT_NOW(a_pend_bound, 1'b1, r_pend != 2'd3, "more than two beats in flight")
    `WRF_ASSERT_NEXT(a_one_in_work, w_in_acc, !o_in_ready, "input taken while busy")
    `WRF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result beat changed")

endmodule

bind wah_resonant_filter_core wrf_checker u_wrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

FILE: bench/tb_top.sv
// testbench: self-checking bench for the wah resonant filter core with its own filter predictor
`timescale 1ns / 1ps

module tb_top;
    import wrf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_OFF      = 400;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam logic [INC_BITS-1:0]    INC_MAX = {1'b0, {(INC_BITS-1){1'b1}}};
    localparam logic [INC_BITS-1:0]    INC_MIN = {1'b1, {(INC_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic signed [127:0] WIDE_HI = (128'sd1 <<< (WIDE - 1)) - 128'sd1;
    localparam logic signed [127:0] WIDE_LO = -(128'sd1 <<< (WIDE - 1));
    localparam logic signed [127:0] SMP_HI  = (128'sd1 <<< (SAMPLE_BITS - 1)) - 128'sd1;
    localparam logic signed [127:0] SMP_LO  = -(128'sd1 <<< (SAMPLE_BITS - 1));

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    t_in_beat                in_beat   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_out_beat               out_beat;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [INC_BITS-1:0]     cfg_data  = '0;

    // predictor copy of the increments and the per-channel filter state
    logic signed [INC_BITS-1:0] gain_inc = '0;
    logic signed [INC_BITS-1:0] fb1_inc  = '0;
    logic signed [INC_BITS-1:0] fb2_inc  = '0;
    logic signed [WIDE-1:0]     y1_mem   [CHANNELS] = '{default: '0};
    logic signed [WIDE-1:0]     y2_mem   [CHANNELS] = '{default: '0};
    logic signed [WIDE-1:0]     gain_mem [CHANNELS] = '{default: '0};
    logic signed [WIDE-1:0]     fb1_mem  [CHANNELS] = '{default: '0};
    logic signed [WIDE-1:0]     fb2_mem  [CHANNELS] = '{default: '0};

    t_out_beat   filtered_queue [$];
    int unsigned error_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned checked_count = 0;
    int unsigned write_count   = 0;
    int          rx_hold_cycles = 0;
    bit          steady_flow    = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    wah_resonant_filter_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic logic signed [WIDE-1:0] clamp_wide(input logic signed [127:0] v);
        if (v > WIDE_HI) return WIDE_HI[WIDE-1:0];
        if (v < WIDE_LO) return WIDE_LO[WIDE-1:0];
        return v[WIDE-1:0];
    endfunction

    // exact product, rounded half up to the given fraction bits, clamped to 48 bits
    function automatic logic signed [WIDE-1:0] mul_round(input logic signed [WIDE-1:0] a,
            input logic signed [WIDE-1:0] b, input int shift);
        logic signed [127:0] wa, wb, p;
        wa = 128'(a);
        wb = 128'(b);
        p = ((wa * wb) + (128'sd1 <<< (shift - 1))) >>> shift;
        return clamp_wide(p);
    endfunction

    function automatic t_out_beat wah_filter_predict(input t_in_beat b);
        int c;
        logic signed [WIDE-1:0] x, g, f1, f2, y0;
        logic signed [127:0]    acc;
        t_out_beat              r;
        c = int'(b.chan);
        r.out_chan   = b.chan;
        r.sample_out = '0;
        if (c >= CHANNELS) return r;
        x = WIDE'($signed(b.sample_in));
        acc = 128'(gain_inc) + 128'(mul_round(K_COEF, gain_mem[c], FRAC));
        g = clamp_wide(acc);
        acc = 128'(fb1_inc) + 128'(mul_round(K_COEF, fb1_mem[c], FRAC));
        f1 = clamp_wide(acc);
        acc = 128'(fb2_inc) + 128'(mul_round(K_COEF, fb2_mem[c], FRAC));
        f2 = clamp_wide(acc);
        acc = 128'(mul_round(g, x, SAMPLE_BITS - 1)) - 128'(mul_round(f1, y1_mem[c], FRAC))
            - 128'(mul_round(f2, y2_mem[c], FRAC));
        y0 = clamp_wide(acc);
        acc = 128'(y0) - 128'(y1_mem[c]);
        acc = (acc + (128'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (acc > SMP_HI) begin
            acc = SMP_HI;
        end else if (acc < SMP_LO) begin
            acc = SMP_LO;
        end
        r.sample_out = acc[SAMPLE_BITS-1:0];
        gain_mem[c] = g;
        fb1_mem[c]  = f1;
        fb2_mem[c]  = f2;
        y2_mem[c]   = y1_mem[c];
        y1_mem[c]   = y0;
        return r;
    endfunction

    function automatic logic [INC_BITS-1:0] draw_increment();
        logic signed [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: r = {{(64-INC_BITS){1'b0}}, INC_MAX};
            1: r = {{(64-INC_BITS){1'b1}}, INC_MIN};
            2: r = '0;
            3, 4: ;
            default: r = r >>> $urandom_range(28, 40);
        endcase
        return r[INC_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        logic signed [SAMPLE_BITS-1:0] r;
        r = SAMPLE_BITS'($urandom);
        case ($urandom_range(0, 9))
            0: r = SMP_MAX;
            1: r = SMP_MIN;
            2, 3: r = r >>> $urandom_range(4, 16);
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [INC_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN_INC: gain_inc = data;
            CFG_FB1_INC:  fb1_inc  = data;
            CFG_FB2_INC:  fb2_inc  = data;
            default: ;
        endcase
        write_count++;
    endtask

    task automatic program_increments(input logic [INC_BITS-1:0] gain,
            input logic [INC_BITS-1:0] fb1, input logic [INC_BITS-1:0] fb2);
        write_reg(CFG_GAIN_INC, gain);
        write_reg(CFG_FB1_INC, fb1);
        write_reg(CFG_FB2_INC, fb2);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic [CHAN_BITS-1:0] ch);
        int       gap;
        t_in_beat beat;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        beat.sample_in = smp;
        beat.chan      = ch;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!in_ready);
        filtered_queue.push_back(wah_filter_predict(beat));
        sent_count++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (filtered_queue.size() != 0) @(posedge clk);
    endtask

    // idle before a register write: all results in, then a settle wait
    task automatic quiesce();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_corners();
        int ch;
        logic [SAMPLE_BITS-1:0] corner [CHANNELS];
        corner = '{SMP_MAX, SMP_MIN, '0, '1, 24'd1, SMP_MAX, SMP_MIN, 24'h5A5A5A};
        // zero increments after reset: gain stays zero, every output zero
        for (ch = 0; ch < CHANNELS; ch++) begin
            send_sample(corner[ch], ch[CHAN_BITS-1:0]);
        end
        quiesce();
        program_increments(INC_MAX, INC_MAX, INC_MAX);
        send_sample(SMP_MAX, 3'd0);
        send_sample(SMP_MIN, 3'd0);
        send_sample(SMP_MAX, 3'd1);
        send_sample(SMP_MAX, 3'd1);
        send_sample(SMP_MIN, 3'd2);
        send_sample('1, 3'd2);
        quiesce();
        program_increments(INC_MIN, INC_MIN, INC_MIN);
        send_sample(SMP_MAX, 3'd3);
        send_sample(SMP_MIN, 3'd3);
        send_sample(SMP_MIN, 3'd0);
        send_sample(SMP_MAX, 3'd0);
        send_sample('0, 3'd4);
        send_sample(24'd1, 3'd4);
        quiesce();
        program_increments(45'h0_0004_0000_0000, -45'sh7_0000_0000, 45'h0_0003_0000_0000);
        // unused index must leave every increment alone
        write_reg(CFG_UNUSED, INC_MAX);
        send_sample(SMP_MAX, 3'd5);
        send_sample(SMP_MIN, 3'd5);
        send_sample('0, 3'd5);
        send_sample(SMP_MAX, 3'd5);
        send_sample(SMP_MIN, 3'd5);
        quiesce();
    endtask

    task automatic test_output_hold_off();
        int k;
        program_increments(draw_increment(), draw_increment(), draw_increment());
        steady_flow    = 1'b1;
        rx_hold_cycles = HOLD_OFF;
        for (k = 0; k < 40; k++) begin
            send_sample(draw_sample(), CHAN_BITS'(k % CHANNELS));
        end
        steady_flow = 1'b0;
        quiesce();
    endtask

    task automatic test_random_settings();
        int p, k;
        logic [CHAN_BITS-1:0] burst_ch;
        for (p = 0; p < PHASES; p++) begin
            program_increments(draw_increment(), draw_increment(), draw_increment());
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_UNUSED, draw_increment());
            end
            burst_ch = CHAN_BITS'($urandom_range(0, CHANNELS - 1));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                steady_flow = ((k / 20) % 5) == 4;
                if (k == PHASE_ITEMS / 2) begin
                    wait_for_results();
                end
                send_sample(draw_sample(),
                    (k % 40 < 12) ? burst_ch : CHAN_BITS'($urandom_range(0, CHANNELS - 1)));
            end
            steady_flow = 1'b0;
            quiesce();
        end
    endtask

    initial begin : result_checker
        int        stall;
        t_out_beat got, want;
        wait (rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 9);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = out_beat;
            checked_count++;
            if (filtered_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected beat sample %0d chan %0d",
                    $signed(got.sample_out), got.out_chan));
            end else begin
                want = filtered_queue.pop_front();
                if (got.sample_out !== want.sample_out) begin
                    report_mismatch($sformatf("beat %0d chan %0d: sample_out %0d, want %0d",
                        checked_count, want.out_chan, $signed(got.sample_out),
                        $signed(want.sample_out)));
                end
                if (got.out_chan !== want.out_chan) begin
                    report_mismatch($sformatf("beat %0d: out_chan %0d, want %0d",
                        checked_count, got.out_chan, want.out_chan));
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_output_hold_off();
        test_random_settings();
        quiesce();
        $display("run covered %0d samples and %0d checked beats over %0d register writes,",
            sent_count, checked_count, write_count);
        $display("incl. saturating increments, the unused index, an output hold-off and drains");
        if (error_count == 0) begin
            $display("** wah_resonant_filter_core: PASSED **");
        end else begin
            $display("** wah_resonant_filter_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("timeout with %0d beats still outstanding", filtered_queue.size());
        $display("** wah_resonant_filter_core: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/wrf_pkg.sv
design/wrf_ram.sv
design/wah_resonant_filter_core.sv
design/wrf_checker.sv
bench/tb_top.sv
